>>> design/srfm_pkg.sv
// Shared types, constants and tables for the register-to-FM translator.
// No dependencies.
package srfm_pkg;

    localparam int NumChannels = 9;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FREQ,
        OP_PULSE,
        OP_CONTROL,
        OP_ATTACK,
        OP_SUSTAIN,
        OP_VOLUME
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] voice;
        logic [7:0] value;
        logic [15:0] word;
    } cmd_t;

    localparam logic [9:0] FnumHigh = 10'h2AE;
    localparam logic [9:0] FnumLow  = 10'h16B;

    // word / 13 == (word * Div13Recip) >> 18 for any 16-bit word
    localparam logic [14:0] Div13Recip = 15'd20165;

    function automatic logic [7:0] op_offset(input logic [3:0] c);
        logic [7:0] r;
        unique case (c)
            4'd0: r = 8'h00;
            4'd1: r = 8'h01;
            4'd2: r = 8'h02;
            4'd3: r = 8'h08;
            4'd4: r = 8'h09;
            4'd5: r = 8'h0A;
            4'd6: r = 8'h10;
            4'd7: r = 8'h11;
            default: r = 8'h12;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] pulse_level(input logic [4:0] i);
        logic [4:0] r;
        if (i < 5'd4) r = i;
        else if (i >= 5'd28) r = 5'h10;
        else r = 5'(({1'b0, i} >> 1) + 6'd2);
        return r;
    endfunction

    function automatic logic [7:0] attack_decay(input logic [7:0] v);
        logic [7:0] a;
        logic [7:0] d;
        unique case (v[7:4])
            4'd0: a = 8'hB0;
            4'd1: a = 8'h90;
            4'd2: a = 8'h80;
            4'd3, 4'd4: a = 8'h70;
            4'd5, 4'd6, 4'd7: a = 8'h60;
            4'd8: a = 8'h50;
            4'd9: a = 8'h40;
            4'd10: a = 8'h30;
            4'd11, 4'd12: a = 8'h20;
            default: a = 8'h10;
        endcase
        unique case (v[3:0])
            4'd0: d = 8'd11;
            4'd1: d = 8'd10;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6: d = 8'd9;
            4'd7: d = 8'd8;
            4'd15: d = 8'd1;
            default: d = 8'(4'd15 - v[3:0]);
        endcase
        return a | d;
    endfunction

    function automatic logic [7:0] sustain_release(input logic [7:0] v);
        logic [7:0] s;
        logic [7:0] r;
        unique case (v[7:4])
            4'd0: s = 8'hF0;
            4'd1: s = 8'h70;
            4'd2: s = 8'h50;
            4'd3: s = 8'h40;
            4'd4, 4'd5: s = 8'h30;
            4'd6, 4'd7, 4'd8: s = 8'h20;
            4'd14, 4'd15: s = 8'h00;
            default: s = 8'h10;
        endcase
        r = (v[3:0] == 4'd15) ? 8'd1 : 8'(4'd15 - v[3:0]);
        return s | r;
    endfunction

endpackage

>>> design/srfm_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on nothing.
interface srfm_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] sid_register;
    logic [7:0] sid_value;
    modport source (output valid, sid_register, sid_value, input ready);
    modport sink (input valid, sid_register, sid_value, output ready);
endinterface

interface srfm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] fm_register;
    logic [7:0] fm_value;
    logic       last;
    modport source (output valid, fm_register, fm_value, last, input ready);
    modport sink (input valid, fm_register, fm_value, last, output ready);
endinterface

>>> design/synth_register_to_fm_translator_top.sv
// Top level of the register-to-FM translator.
// Depends on srfm_pkg, srfm_if, srfm_front and srfm_back.
//
// A register write that maps to a command is registered in the front end and
// handed to the back end once that is idle; the back end then runs 0 to 36 FM
// writes, one per cycle while the result channel is ready, and steps past each
// replayed channel that has nothing to write. Frequency writes add a
// reciprocal-multiply step for the division by 13 and octave-normalize steps;
// control writes add a step of their own. A waiting command blocks further
// input until the back end is idle. The last write of a burst is marked on out_ch.
module synth_register_to_fm_translator_top
    import srfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    srfm_in_if.sink    in_ch,
    srfm_out_if.source out_ch
);
    logic enable_reg;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) enable_reg <= 1'b0;
        else if (cfg_we) enable_reg <= cfg_wdata;
    end

    srfm_front u_front (
        .clk(clk), .rst_n(rst_n), .enable(enable_reg), .in_ch(in_ch),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
    );

    srfm_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_ready(cmd_ready), .out_ch(out_ch)
    );
endmodule

>>> design/srfm_front.sv
// Front end: register shadow and classification of input items into commands.
// Depends on srfm_pkg and srfm_if.
module srfm_front
    import srfm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enable,
    srfm_in_if.sink       in_ch,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  logic          cmd_ready
);
    logic [7:0] shadow_reg [32];
    logic       full_reg;
    cmd_t       cmd_reg;
    logic [4:0] r;
    logic [1:0] v;
    logic [2:0] k;
    logic [4:0] lo_addr;
    logic [7:0] lo;
    logic [7:0] hi;
    cmd_t       c_next;

    assign in_ch.ready = !full_reg;
    assign cmd_valid = full_reg;
    assign cmd = cmd_reg;
    assign r = in_ch.sid_register;

    always_comb
    begin
        if (r < 5'd7) begin v = 2'd0; k = 3'(r); end
        else if (r < 5'd14) begin v = 2'd1; k = 3'(r - 5'd7); end
        else begin v = 2'd2; k = 3'(r - 5'd14); end
        lo_addr = (k[2:1] == 2'b00) ? 5'(5'(v) * 5'd7) : 5'(5'(v) * 5'd7 + 5'd2);
        lo = (lo_addr == r) ? in_ch.sid_value : shadow_reg[lo_addr];
        hi = ((lo_addr + 5'd1) == r) ? in_ch.sid_value : shadow_reg[lo_addr + 5'd1];
        c_next.voice = v;
        c_next.value = in_ch.sid_value;
        c_next.word = {hi, lo};
        if (!enable) c_next.op = OP_NONE;
        else if (r == 5'd24) c_next.op = OP_VOLUME;
        else if (r >= 5'd21) c_next.op = OP_NONE;
        else begin
            unique case (k)
                3'd0, 3'd1: c_next.op = OP_FREQ;
                3'd2, 3'd3: c_next.op = OP_PULSE;
                3'd4: c_next.op = OP_CONTROL;
                3'd5: c_next.op = OP_ATTACK;
                default: c_next.op = OP_SUSTAIN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
            cmd_reg <= '0;
            for (int i = 0; i < 32; i++)
                shadow_reg[i] <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) shadow_reg[r] <= in_ch.sid_value;
            if (in_ch.valid && in_ch.ready && c_next.op != OP_NONE) begin
                full_reg <= 1'b1;
                cmd_reg <= c_next;
            end else if (cmd_ready) begin
                full_reg <= 1'b0;
            end
        end
    end
endmodule

>>> design/srfm_back.sv
// Back end: channel state and sequencer that emits FM writes, one per cycle while out_ch is ready.
// Depends on srfm_pkg and srfm_if.
module srfm_back
    import srfm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  cmd_t     cmd,
    output logic     cmd_ready,
    srfm_out_if.source out_ch
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_NORM, S_CTRL, S_ENV, S_REPLAY
    } state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic        gate_reg [NumChannels];
    logic [12:0] freq_reg [NumChannels];
    logic [4:0]  pulse_reg [NumChannels];
    logic [15:0] sound_reg [NumChannels];
    logic [5:0]  master_reg;
    logic        voice3_reg;
    logic [12:0] quo_reg;
    logic        norm_down_reg;
    logic [2:0]  oct_reg;
    logic [3:0]  ch_reg;
    logic [3:0]  ch_end_reg;
    logic [1:0]  sub_reg;
    logic [2:0]  env_reg;
    logic        out_valid_reg;
    logic [7:0]  out_reg_reg;
    logic [7:0]  out_val_reg;
    logic        out_last_reg;

    logic [3:0]  base;
    logic [3:0]  pulse_ch;
    logic [30:0] prod;
    logic        stall;
    logic [7:0]  p;
    logic [5:0]  lvl;
    logic [15:0] f;
    logic        chan_has;
    logic        chan_done;
    logic        later_has;
    logic [3:0]  wave;
    logic [7:0]  env_x;
    logic [7:0]  env_p;
    logic        last_ch;

    assign stall = out_valid_reg && !out_ch.ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.fm_register = out_reg_reg;
    assign out_ch.fm_value = out_val_reg;
    assign out_ch.last = out_last_reg;
    assign base = {1'b0, cmd_reg.voice, 1'b0} + {2'b0, cmd_reg.voice};
    assign pulse_ch = {1'b0, cmd.voice, 1'b0} + {2'b0, cmd.voice} + 4'd2;
    assign prod = cmd_reg.word * Div13Recip;
    assign p = op_offset(ch_reg);
    assign lvl = (ch_reg == 4'd2 || ch_reg == 4'd5 || ch_reg == 4'd8)
                 ? {1'b0, pulse_reg[ch_reg]} : master_reg;
    assign f = gate_reg[ch_reg] ? {3'b0, freq_reg[ch_reg]} : sound_reg[ch_reg];
    assign chan_has = gate_reg[ch_reg] || (sound_reg[ch_reg] != 16'd0);
    assign chan_done = !chan_has || sub_reg == 2'd3;
    assign last_ch = (ch_reg == ch_end_reg);
    assign wave = cmd_reg.value[7:4];
    assign env_x = (cmd_reg.op == OP_ATTACK) ? attack_decay(cmd_reg.value)
                                             : sustain_release(cmd_reg.value);
    assign env_p = op_offset(4'(base + {2'b0, env_reg[2:1]}));

    always_comb
    begin
        later_has = 1'b0;
        for (int j = 0; j < NumChannels; j++)
            if (4'(j) > ch_reg && 4'(j) <= ch_end_reg &&
                (gate_reg[j] || sound_reg[j] != 16'd0))
                later_has = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cmd_reg <= '0;
            for (int i = 0; i < NumChannels; i++) begin
                gate_reg[i] <= 1'b0;
                freq_reg[i] <= '0;
                pulse_reg[i] <= '0;
                sound_reg[i] <= '0;
            end
            master_reg <= '0;
            voice3_reg <= 1'b0;
            quo_reg <= '0;
            norm_down_reg <= 1'b0;
            oct_reg <= '0;
            ch_reg <= '0;
            ch_end_reg <= '0;
            sub_reg <= '0;
            env_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg_reg <= '0;
            out_val_reg <= '0;
            out_last_reg <= 1'b0;
        end else begin
            logic out_valid_next;
            out_valid_next = stall;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid) begin
                        cmd_reg <= cmd;
                        sub_reg <= '0;
                        env_reg <= '0;
                        unique case (cmd.op)
                            OP_FREQ: state_reg <= S_DIV;
                            OP_PULSE:
                            begin
                                ch_reg <= pulse_ch;
                                ch_end_reg <= pulse_ch;
                                pulse_reg[pulse_ch] <= pulse_level(cmd.word[11:7]);
                                state_reg <= S_REPLAY;
                            end
                            OP_CONTROL: state_reg <= S_CTRL;
                            OP_ATTACK, OP_SUSTAIN: state_reg <= S_ENV;
                            OP_VOLUME:
                            begin
                                voice3_reg <= cmd.value[7];
                                master_reg <= 6'd31 - {1'b0, cmd.value[3:0], 1'b0};
                                ch_reg <= 4'd0;
                                ch_end_reg <= 4'd8;
                                state_reg <= S_REPLAY;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_DIV:
                begin
                    quo_reg <= prod[30:18];
                    oct_reg <= 3'd4;
                    norm_down_reg <= 1'b0;
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (!norm_down_reg && quo_reg > {3'b0, FnumHigh}) begin
                        quo_reg <= quo_reg >> 1;
                        oct_reg <= oct_reg + 3'd1;
                    end else if (oct_reg != 3'd0 && quo_reg < {3'b0, FnumLow}) begin
                        norm_down_reg <= 1'b1;
                        quo_reg <= quo_reg << 1;
                        oct_reg <= oct_reg - 3'd1;
                    end else begin
                        for (int i = 0; i < 3; i++)
                            freq_reg[4'(base + 4'(i))] <= {oct_reg, quo_reg[9:0]};
                        ch_reg <= base;
                        ch_end_reg <= base + 4'd2;
                        state_reg <= S_REPLAY;
                    end
                end
                S_CTRL:
                begin
                    if (!stall) begin
                        logic [3:0] w;
                        logic [2:0] g;
                        w = (cmd_reg.voice == 2'd2 && !voice3_reg) ? 4'd9 : wave;
                        if (w == 4'd0) w = 4'd9;
                        g = 3'b000;
                        if (w < 4'd9 && cmd_reg.value[0]) begin
                            out_valid_next = 1'b1;
                            out_reg_reg <= 8'hC0 + {4'b0, base};
                            out_last_reg <= 1'b0;
                            if (w == 4'd8) begin
                                out_val_reg <= 8'h0E;
                                g = 3'b001;
                            end else begin
                                out_val_reg <= 8'h01;
                                g = w[2:0];
                            end
                        end
                        for (int i = 0; i < 3; i++) gate_reg[4'(base + 4'(i))] <= g[i];
                        ch_reg <= base;
                        ch_end_reg <= base + 4'd2;
                        state_reg <= S_REPLAY;
                    end
                end
                S_ENV:
                begin
                    if (!stall) begin
                        out_valid_next = 1'b1;
                        out_reg_reg <= ((cmd_reg.op == OP_ATTACK) ? 8'h60 : 8'h80)
                                       + (env_reg[0] ? 8'd3 : 8'd0) + env_p;
                        out_val_reg <= env_x;
                        out_last_reg <= (env_reg == 3'd5);
                        env_reg <= env_reg + 3'd1;
                        if (env_reg == 3'd5) state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    if (!stall) begin
                        if (chan_has) begin
                            out_valid_next = 1'b1;
                            if (gate_reg[ch_reg] && sub_reg < 2'd2) begin
                                out_reg_reg <= 8'h40 + p + (sub_reg[0] ? 8'd3 : 8'd0);
                                out_val_reg <= {2'b0, lvl};
                                out_last_reg <= 1'b0;
                            end else if (!sub_reg[0]) begin
                                out_reg_reg <= 8'hA0 + {4'b0, ch_reg};
                                out_val_reg <= f[7:0];
                                out_last_reg <= 1'b0;
                            end else begin
                                out_reg_reg <= 8'hB0 + {4'b0, ch_reg};
                                out_val_reg <= f[15:8] | (gate_reg[ch_reg] ? 8'h20 : 8'h00);
                                sound_reg[ch_reg] <= gate_reg[ch_reg] ? f : 16'd0;
                                out_last_reg <= !later_has;
                            end
                        end
                        if (chan_done) begin
                            sub_reg <= '0;
                            if (last_ch)
                                state_reg <= S_IDLE;
                            else
                                ch_reg <= ch_reg + 4'd1;
                        end else if (!gate_reg[ch_reg] && sub_reg == 2'd0) begin
                            sub_reg <= 2'd3;
                        end else begin
                            sub_reg <= sub_reg + 2'd1;
                        end
                    end
                end
            endcase
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
